// File: design/mvtc_pkg.sv
// Shared types, codes and constants for the motor valve travel controller.
package mvtc_pkg;

	// Width of the held close time; now_seconds is cut or zero-extended to it.
	localparam int TIME_BITS = 32;

	localparam int NOW_BITS     = 32;
	localparam int TANK_BITS    = 8;
	localparam int CFG_BITS     = 16;
	localparam int CFG_IDX_BITS = 8;

	localparam logic [TANK_BITS-1:0] TANK_FULL_PERCENT = 8'd100;

	localparam logic [CFG_BITS-1:0] TRAVEL_RESET  = 16'd60;
	localparam logic [CFG_BITS-1:0] LOCKOUT_RESET = 16'd300;

	// Configuration register indexes.
	localparam logic [CFG_IDX_BITS-1:0] REG_TRAVEL  = 8'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_LOCKOUT = 8'd1;

	// Item kinds.
	localparam logic KIND_COMMAND = 1'b0;
	localparam logic KIND_TICK    = 1'b1;

	typedef enum logic [1:0] {
		MODE_CLOSED  = 2'd0,
		MODE_OPENING = 2'd1,
		MODE_OPEN    = 2'd2,
		MODE_CLOSING = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		DRIVE_OFF   = 2'd0,
		DRIVE_OPEN  = 2'd1,
		DRIVE_CLOSE = 2'd2
	} drive_t;

	typedef enum logic [1:0] {
		REFUSE_NONE      = 2'd0,
		REFUSE_LOCKOUT   = 2'd1,
		REFUSE_TANK_FULL = 2'd2
	} refuse_t;

	typedef struct packed {
		logic                 kind;
		logic                 open_request;
		logic [NOW_BITS-1:0]  now_seconds;
		logic [TANK_BITS-1:0] tank_percent;
	} item_t;

	typedef struct packed {
		logic [CFG_BITS-1:0] travel_seconds;
		logic [CFG_BITS-1:0] reopen_lockout_seconds;
	} cfg_t;

	typedef struct packed {
		logic [1:0] motor_drive;
		logic [1:0] valve_status;
		logic [1:0] refused;
	} result_t;

endpackage

// File: design/motor_valve_travel_controller.sv
// Top level: input stage, valve state machine, result register, config port.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+--------------------------------------
//  in      | sink      | in_valid / in_stall   | kind, open_request, now_seconds,
//          |           |                       | tank_percent
//  out     | source    | out_valid / out_stall | motor_drive, valve_status, refused
//  cfg     | sink      | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Each item passes through the input register and then the result register before
// it can transfer out. One item per cycle is sustained while out_stall is low; the
// valve state updates as an item moves from the input register to the result
// register, so the next item in the input register sees it with no bubble.
// Reset clears valid bits, valve state (closed, no travel, close time zero) and
// loads travel 60 s, lockout 300 s. in_stall rises only when the input register
// is full and the result register is held by out_stall. cfg_ready is always high.
module motor_valve_travel_controller (
	input  logic                                clk,
	input  logic                                arst_n,

	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                kind,
	input  logic                                open_request,
	input  logic [mvtc_pkg::NOW_BITS-1:0]       now_seconds,
	input  logic [mvtc_pkg::TANK_BITS-1:0]      tank_percent,

	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [1:0]                          motor_drive,
	output logic [1:0]                          valve_status,
	output logic [1:0]                          refused,

	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [mvtc_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [mvtc_pkg::CFG_BITS-1:0]       cfg_data
);

	logic              valid_s1;
	mvtc_pkg::item_t   item_s1;
	logic              valid_s2;
	mvtc_pkg::result_t result_s2;

	mvtc_pkg::cfg_t    cfg;
	mvtc_pkg::result_t result;
	logic              advance;
	logic              in_xfer;

	assign cfg_ready = 1'b1;

	mvtc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// stage 1 item moves on when the result register is empty or being drained
	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_xfer  = in_valid && !in_stall;

	mvtc_valve_fsm u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.result (result)
	);

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_xfer) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			item_s1.kind         <= kind;
			item_s1.open_request <= open_request;
			item_s1.now_seconds  <= now_seconds;
			item_s1.tank_percent <= tank_percent;
		end
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign out_valid    = valid_s2;
	assign motor_drive  = result_s2.motor_drive;
	assign valve_status = result_s2.valve_status;
	assign refused      = result_s2.refused;

	// a held result must not be overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && out_stall) |-> !advance)
		else $error("result register overwritten while stalled");

	// a stalled stage 1 item is kept for the next cycle
	a_s1_keep: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> valid_s1)
		else $error("stage 1 item lost");

	// every item that leaves stage 1 shows up as a result
	a_s2_fill: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("advanced item missing from result register");

endmodule

// File: design/mvtc_cfg_regs.sv
// Configuration registers: travel time and reopen lockout.
module mvtc_cfg_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               wr_en,
	input  logic [mvtc_pkg::CFG_IDX_BITS-1:0]  wr_index,
	input  logic [mvtc_pkg::CFG_BITS-1:0]      wr_data,
	output mvtc_pkg::cfg_t                     cfg
);

	logic [mvtc_pkg::CFG_BITS-1:0] travel_q;
	logic [mvtc_pkg::CFG_BITS-1:0] lockout_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			travel_q  <= mvtc_pkg::TRAVEL_RESET;
			lockout_q <= mvtc_pkg::LOCKOUT_RESET;
		end else if (wr_en) begin
			// unknown indexes are dropped
			if (wr_index == mvtc_pkg::REG_TRAVEL) begin
				travel_q <= wr_data;
			end
			if (wr_index == mvtc_pkg::REG_LOCKOUT) begin
				lockout_q <= wr_data;
			end
		end
	end

	assign cfg.travel_seconds         = travel_q;
	assign cfg.reopen_lockout_seconds = lockout_q;

endmodule

// File: design/mvtc_valve_fsm.sv
// Valve mode state machine with travel counter and lockout check.
module mvtc_valve_fsm (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  mvtc_pkg::item_t   item,
	input  mvtc_pkg::cfg_t    cfg,
	output mvtc_pkg::result_t result
);

	mvtc_pkg::mode_t                     mode_q, mode_d;
	logic [mvtc_pkg::CFG_BITS-1:0]       travel_q, travel_d;
	logic [mvtc_pkg::TIME_BITS-1:0]      last_close_q, last_close_d;

	logic [mvtc_pkg::TIME_BITS-1:0]      now;
	logic [mvtc_pkg::TIME_BITS:0]        since_close;
	logic                                shut;
	logic                                moving;
	logic                                locked;
	logic                                tank_full;
	logic                                is_tick;

	assign now         = mvtc_pkg::TIME_BITS'(item.now_seconds);
	// extra top bit is the borrow: set when now is before the last close
	assign since_close = {1'b0, now} - {1'b0, last_close_q};
	assign locked      = since_close[mvtc_pkg::TIME_BITS]
		|| (since_close[mvtc_pkg::TIME_BITS-1:0]
			< mvtc_pkg::TIME_BITS'(cfg.reopen_lockout_seconds));
	assign tank_full   = item.tank_percent >= mvtc_pkg::TANK_FULL_PERCENT;
	assign shut        = mode_q inside {mvtc_pkg::MODE_CLOSED, mvtc_pkg::MODE_CLOSING};
	assign moving      = mode_q inside {mvtc_pkg::MODE_OPENING, mvtc_pkg::MODE_CLOSING};
	assign is_tick     = item.kind == mvtc_pkg::KIND_TICK;

	// next state
	always_comb begin
		mode_d       = mode_q;
		travel_d     = travel_q;
		last_close_d = last_close_q;
		if (step) begin
			if (is_tick) begin
				if (moving) begin
					if (travel_q <= mvtc_pkg::CFG_BITS'(1)) begin
						travel_d = '0;
						mode_d   = (mode_q == mvtc_pkg::MODE_OPENING)
							? mvtc_pkg::MODE_OPEN : mvtc_pkg::MODE_CLOSED;
					end else begin
						travel_d = travel_q - mvtc_pkg::CFG_BITS'(1);
					end
				end
			end else if (item.open_request) begin
				if (shut && !locked && !tank_full) begin
					mode_d   = mvtc_pkg::MODE_OPENING;
					travel_d = cfg.travel_seconds;
				end
			end else if (!shut) begin
				last_close_d = now;
				mode_d       = mvtc_pkg::MODE_CLOSING;
				travel_d     = cfg.travel_seconds;
			end
		end
	end

	// result of the item being processed
	always_comb begin
		result.valve_status = mode_d;
		case (mode_d)
			mvtc_pkg::MODE_OPENING: result.motor_drive = mvtc_pkg::DRIVE_OPEN;
			mvtc_pkg::MODE_CLOSING: result.motor_drive = mvtc_pkg::DRIVE_CLOSE;
			default:                result.motor_drive = mvtc_pkg::DRIVE_OFF;
		endcase
		result.refused = mvtc_pkg::REFUSE_NONE;
		if (!is_tick && item.open_request) begin
			if (shut && locked) begin
				result.refused = mvtc_pkg::REFUSE_LOCKOUT;
			end else if (tank_full) begin
				result.refused = mvtc_pkg::REFUSE_TANK_FULL;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= mvtc_pkg::MODE_CLOSED;
			travel_q     <= '0;
			last_close_q <= '0;
		end else begin
			mode_q       <= mode_d;
			travel_q     <= travel_d;
			last_close_q <= last_close_d;
		end
	end

	// at rest the travel count is always spent
	a_rest_no_travel: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == mvtc_pkg::MODE_OPEN || mode_q == mvtc_pkg::MODE_CLOSED)
		|-> travel_q == '0)
		else $error("travel count left while valve at rest");

	// close time only moves on a close command that starts closing
	a_close_time: assert property (@(posedge clk) disable iff (!arst_n)
		!(step && !is_tick && !item.open_request && !shut) |=> $stable(last_close_q))
		else $error("close time changed without accepted close");

	// a tick never disturbs a valve at rest
	a_tick_at_rest: assert property (@(posedge clk) disable iff (!arst_n)
		(step && is_tick && !moving) |=> $stable(mode_q))
		else $error("tick moved a valve at rest");

	// a refused open leaves the mode alone
	a_refuse_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(step && result.refused != mvtc_pkg::REFUSE_NONE) |=> $stable(mode_q))
		else $error("refused command changed valve mode");

endmodule
